[design/spnc_pkg.sv]
// shared types and constants of the scan point normal classifier
package spnc_pkg;

  localparam int VW = 18;

  localparam logic CMD_STORE    = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  localparam logic [1:0] CLS_LINE     = 2'd0;
  localparam logic [1:0] CLS_CORNER   = 2'd1;
  localparam logic [1:0] CLS_ISOLATED = 2'd2;

  localparam logic [1:0] REG_MIN_DIST = 2'd0;
  localparam logic [1:0] REG_MAX_DIST = 2'd1;
  localparam logic [1:0] REG_COS_THR  = 2'd2;
  localparam logic [1:0] REG_INVALID  = 2'd3;

  localparam logic [15:0] MIN_DIST_RST = 16'd25;
  localparam logic [15:0] MAX_DIST_RST = 16'd1000;
  localparam logic [14:0] COS_THR_RST  = 15'd7094;
  localparam logic [15:0] INVALID_RST  = 16'h8000;

  localparam logic [15:0] UNIT_ONE = 16'd16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIMITS,
    ST_WT_P,
    ST_NB_CHK,
    ST_NB_DIFF,
    ST_NB_SQ,
    ST_NB_CMP,
    ST_NORM_WT,
    ST_SIDE_END,
    ST_COMB_MUL,
    ST_COMB_DOT,
    ST_SUM_WT,
    ST_OUT
  } spnc_state_e;

  typedef enum logic [2:0] {
    NM_IDLE,
    NM_SQ,
    NM_SUM,
    NM_SQRT,
    NM_DINIT,
    NM_DIV,
    NM_DONE
  } spnc_norm_state_e;

  typedef struct packed {
    logic                 start;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
  } spnc_norm_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
  } spnc_norm_rsp_t;

endpackage

[design/scan_point_normal_classifier.sv]
// scan point normal classifier top level: command sequencer and side walk
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+----------------------------
//  command  | command/point_index/x/y/count _i        | start high, busy low
//  result   | result_index/normal_x/normal_y/class _o | result_valid_o, one cycle
//  config   | cfg_index_i, cfg_data_i                 | cfg_valid_i and cfg_ready_o
//
// a store transaction leaves busy low
// a classify transaction walks neighbours on both sides and runs each normalisation
// (26-step square root, two 16-step divisions) on one shared normaliser,
// for up to three normalisations
// the point store is never cleared; reset only clears control state and registers
// results cannot be stalled; busy stays high until the result strobe
module scan_point_normal_classifier #(
  parameter int MAX_POINTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               command_i,
  input  logic [9:0]         point_index_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic [10:0]        point_count_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic [9:0]         result_index_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic [1:0]         point_class_o
);
  import spnc_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int JW = CW + 1;
  localparam int EW = 18;

  spnc_state_e state_q, state_d;

  logic [15:0]           min_q, max_q, inv_q;
  logic [14:0]           thr_q;
  logic [9:0]            idx_q;
  logic [CW-1:0]         cnt_q;
  logic signed [JW-1:0]  j_q;
  logic                  side_q;
  logic signed [15:0]    px_q, py_q;
  logic signed [16:0]    dx_q, dy_q;
  logic [33:0]           dx2_q, dy2_q;
  logic [31:0]           dmin2_q, dmax2_q;
  logic signed [15:0]    lx_q, ly_q, rx_q, ry_q;
  logic                  fl_q, fr_q;
  logic signed [31:0]    pxx_q, pyy_q;
  logic signed [15:0]    out_nx_q, out_ny_q;
  logic [1:0]            out_cls_q;
  logic                  res_valid_q;

  logic                  accept;
  logic [EW-1:0]         idx_ext, cnt_ext, cnt_clamp;
  logic                  in_range, store_ok;
  logic                  mem_we;
  logic [AW-1:0]         raddr;
  logic [31:0]           rdata;
  logic signed [15:0]    mem_x, mem_y;
  logic                  j_ok;
  logic [34:0]           d2;
  logic                  nb_take, nb_beyond;
  logic [15:0]           dmin;
  logic signed [16:0]    sx, sy;
  logic signed [32:0]    dot;
  logic [32:0]           adot;
  logic                  is_line;
  spnc_norm_req_t        nreq;
  spnc_norm_rsp_t        nrsp;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign idx_ext   = EW'(point_index_i);
  assign cnt_ext   = EW'(point_count_i);
  assign cnt_clamp = (cnt_ext > EW'(MAX_POINTS)) ? EW'(MAX_POINTS) : cnt_ext;
  assign in_range  = idx_ext < cnt_clamp;
  assign store_ok  = idx_ext < EW'(MAX_POINTS);
  assign mem_we    = accept && (command_i == CMD_STORE) && store_ok;

  assign mem_x = rdata[31:16];
  assign mem_y = rdata[15:0];

  assign j_ok      = !j_q[JW-1] && (j_q < $signed({1'b0, cnt_q}));
  assign d2        = {1'b0, dx2_q} + {1'b0, dy2_q};
  assign nb_take   = (d2 >= 35'(dmin2_q)) && (d2 <= 35'(dmax2_q));
  assign nb_beyond = d2 > 35'(dmax2_q);
  assign dmin      = (min_q == 16'd0) ? 16'd1 : min_q;

  assign sx      = 17'(lx_q) + 17'(rx_q);
  assign sy      = 17'(ly_q) + 17'(ry_q);
  assign dot     = 33'(pxx_q) + 33'(pyy_q);
  assign adot    = dot[32] ? 33'(-dot) : 33'(dot);
  assign is_line = adot >= 33'({thr_q, 14'd0});

  spnc_store #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(idx_ext)),
    .wdata_i ({point_x_i, point_y_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  spnc_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (nreq),
    .rsp_o  (nrsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (command_i == CMD_CLASSIFY) && in_range) state_d = ST_LIMITS;
      end
      ST_LIMITS:  state_d = ST_WT_P;
      ST_WT_P:    state_d = ST_NB_CHK;
      ST_NB_CHK:  state_d = j_ok ? ST_NB_DIFF : ST_SIDE_END;
      ST_NB_DIFF: state_d = ST_NB_SQ;
      ST_NB_SQ:   state_d = ST_NB_CMP;
      ST_NB_CMP: begin
        if (nb_take) begin
          state_d = ST_NORM_WT;
        end else if (nb_beyond) begin
          state_d = ST_SIDE_END;
        end else begin
          state_d = ST_NB_CHK;
        end
      end
      ST_NORM_WT:  if (nrsp.done) state_d = ST_SIDE_END;
      ST_SIDE_END: state_d = side_q ? ST_COMB_MUL : ST_NB_CHK;
      ST_COMB_MUL: state_d = (fl_q && fr_q) ? ST_COMB_DOT : ST_OUT;
      ST_COMB_DOT: state_d = ((sx == '0) && (sy == '0)) ? ST_OUT : ST_SUM_WT;
      ST_SUM_WT:   if (nrsp.done) state_d = ST_OUT;
      ST_OUT:      state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    raddr      = j_q[AW-1:0];
    nreq.start = 1'b0;
    nreq.vx    = VW'(dy_q);
    nreq.vy    = -VW'(dx_q);
    case (state_q)
      ST_LIMITS: raddr = AW'(idx_q);
      ST_NB_CMP: nreq.start = nb_take;
      ST_COMB_DOT: begin
        nreq.start = !((sx == '0) && (sy == '0));
        nreq.vx    = VW'(sx);
        nreq.vy    = VW'(sy);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      min_q       <= MIN_DIST_RST;
      max_q       <= MAX_DIST_RST;
      thr_q       <= COS_THR_RST;
      inv_q       <= INVALID_RST;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == ST_OUT);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MIN_DIST: min_q <= cfg_data_i;
          REG_MAX_DIST: max_q <= cfg_data_i;
          REG_COS_THR:  thr_q <= cfg_data_i[14:0];
          REG_INVALID:  inv_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        idx_q <= point_index_i;
        cnt_q <= CW'(cnt_clamp);
      end
      ST_LIMITS: begin
        dmin2_q <= dmin * dmin;
        dmax2_q <= max_q * max_q;
      end
      ST_WT_P: begin
        px_q   <= mem_x;
        py_q   <= mem_y;
        side_q <= 1'b0;
        fl_q   <= 1'b0;
        fr_q   <= 1'b0;
        j_q    <= JW'(idx_q) - JW'(1);
      end
      ST_NB_DIFF: begin
        dx_q <= 17'(px_q) - 17'(mem_x);
        dy_q <= 17'(py_q) - 17'(mem_y);
      end
      ST_NB_SQ: begin
        dx2_q <= 34'(34'(dx_q) * 34'(dx_q));
        dy2_q <= 34'(34'(dy_q) * 34'(dy_q));
      end
      ST_NB_CMP: begin
        if (side_q) begin
          j_q <= j_q + JW'(1);
        end else begin
          j_q <= j_q - JW'(1);
        end
      end
      ST_NORM_WT: begin
        if (nrsp.done) begin
          if (side_q) begin
            fr_q <= 1'b1;
            rx_q <= -nrsp.nx;
            ry_q <= -nrsp.ny;
          end else begin
            fl_q <= 1'b1;
            lx_q <= nrsp.nx;
            ly_q <= nrsp.ny;
          end
        end
      end
      ST_SIDE_END: begin
        side_q <= 1'b1;
        j_q    <= JW'(idx_q) + JW'(1);
      end
      ST_COMB_MUL: begin
        pxx_q <= lx_q * rx_q;
        pyy_q <= ly_q * ry_q;
        out_cls_q <= CLS_LINE;
        if (fl_q) begin
          out_nx_q <= lx_q;
          out_ny_q <= ly_q;
        end else if (fr_q) begin
          out_nx_q <= rx_q;
          out_ny_q <= ry_q;
        end else begin
          out_cls_q <= CLS_ISOLATED;
          out_nx_q  <= inv_q;
          out_ny_q  <= inv_q;
        end
      end
      ST_COMB_DOT: begin
        out_cls_q <= is_line ? CLS_LINE : CLS_CORNER;
        out_nx_q  <= inv_q;
        out_ny_q  <= inv_q;
      end
      ST_SUM_WT: begin
        if (nrsp.done) begin
          out_nx_q <= nrsp.nx;
          out_ny_q <= nrsp.ny;
        end
      end
      default: ;
    endcase
  end

  assign result_valid_o = res_valid_q;
  assign result_index_o = idx_q;
  assign normal_x_o     = out_nx_q;
  assign normal_y_o     = out_ny_q;
  assign point_class_o  = out_cls_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) result_valid_o |-> !busy)
    else $error("result strobe while sequencer busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (point_class_o == CLS_LINE || point_class_o == CLS_CORNER ||
                        point_class_o == CLS_ISOLATED))
    else $error("bad point class");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && point_class_o == CLS_ISOLATED) |-> (normal_x_o == normal_y_o))
    else $error("isolated point with differing normal components");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NB_DIFF) |-> ($past(state_q) == ST_NB_CHK))
    else $error("neighbour data used without a read");
`endif

endmodule

[design/spnc_store.sv]
// point store: one write port, one registered read port
module spnc_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/spnc_norm.sv]
// vector normaliser: squares, bit-serial square root, shared restoring divider
module spnc_norm (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  spnc_pkg::spnc_norm_req_t req_i,
  output spnc_pkg::spnc_norm_rsp_t rsp_o
);
  import spnc_pkg::*;

  localparam int SW = 2 * VW + 16;
  localparam int LW = SW / 2;
  localparam int RW = VW + 24;

  spnc_norm_state_e state_q, state_d;

  logic signed [VW-1:0]   vx_q, vy_q;
  logic [2*VW-1:0]        sqx_q, sqy_q;
  logic [SW-1:0]          rem_q, res_q, bit_q;
  logic [LW-1:0]          len_q;
  logic [RW-1:0]          r_q, dsh_q;
  logic [15:0]            quo_q;
  logic [3:0]             step_q;
  logic                   comp_q;
  logic signed [15:0]     nx_q, ny_q;
  logic                   done_q;

  logic signed [2*VW-1:0] prod_x, prod_y;
  logic [2*VW-1:0]        s2;
  logic [SW-1:0]          trial;
  logic [SW-1:0]          res_next;
  logic signed [VW-1:0]   cv;
  logic [VW-1:0]          mag;
  logic [15:0]            quo_next;
  logic [15:0]            quo_sat;
  logic signed [15:0]     comp_val;

  assign prod_x   = vx_q * vx_q;
  assign prod_y   = vy_q * vy_q;
  assign s2       = sqx_q + sqy_q;
  assign trial    = res_q + bit_q;
  assign res_next = (rem_q >= trial) ? ((res_q >> 1) + bit_q) : (res_q >> 1);
  assign cv       = comp_q ? vy_q : vx_q;
  assign mag      = cv[VW-1] ? VW'(-cv) : VW'(cv);
  assign quo_next = {quo_q[14:0], (r_q >= dsh_q)};
  assign quo_sat  = (quo_next > UNIT_ONE) ? UNIT_ONE : quo_next;
  assign comp_val = cv[VW-1] ? -$signed(quo_sat) : $signed(quo_sat);

  always_comb begin
    state_d = state_q;
    case (state_q)
      NM_IDLE:  if (req_i.start) state_d = NM_SQ;
      NM_SQ:    state_d = NM_SUM;
      NM_SUM:   state_d = NM_SQRT;
      NM_SQRT:  if (bit_q == SW'(1)) state_d = NM_DINIT;
      NM_DINIT: state_d = NM_DIV;
      NM_DIV: begin
        if (step_q == 4'd15) begin
          state_d = comp_q ? NM_DONE : NM_DINIT;
        end
      end
      NM_DONE:  state_d = NM_IDLE;
      default:  state_d = NM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NM_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == NM_DIV) && (step_q == 4'd15) && comp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      NM_IDLE: begin
        vx_q <= req_i.vx;
        vy_q <= req_i.vy;
      end
      NM_SQ: begin
        sqx_q <= prod_x;
        sqy_q <= prod_y;
      end
      NM_SUM: begin
        rem_q <= {s2, 16'd0};
        res_q <= '0;
        bit_q <= SW'(1) << (SW - 2);
      end
      NM_SQRT: begin
        if (rem_q >= trial) begin
          rem_q <= rem_q - trial;
        end
        res_q  <= res_next;
        bit_q  <= bit_q >> 2;
        comp_q <= 1'b0;
        len_q  <= res_next[LW-1:0];
      end
      NM_DINIT: begin
        r_q    <= RW'({mag, 22'd0}) + RW'(len_q >> 1);
        dsh_q  <= RW'(len_q) << 15;
        quo_q  <= '0;
        step_q <= '0;
      end
      NM_DIV: begin
        if (r_q >= dsh_q) begin
          r_q <= r_q - dsh_q;
        end
        dsh_q  <= dsh_q >> 1;
        quo_q  <= quo_next;
        step_q <= step_q + 4'd1;
        if (step_q == 4'd15) begin
          if (comp_q) begin
            ny_q <= comp_val;
          end else begin
            nx_q <= comp_val;
          end
          comp_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.nx   = nx_q;
  assign rsp_o.ny   = ny_q;

endmodule
